// File: design/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg
// shared types, constants and helpers of the tournament branch predictor
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

    // default table and history sizes
    localparam int INDEX_BITS_DEF   = 15;
    localparam int HISTORY_BITS_DEF = 15;

    // saturating counter range
    localparam logic [1:0] COUNTER_MAX = 2'd3;
    localparam logic [1:0] COUNTER_MIN = 2'd0;

    // request codes
    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRED,
        ST_UPD
    } t_state;

    // 2-bit saturating counter step
    function automatic logic [1:0] train_ctr(input logic [1:0] ctr, input logic up);
        logic [1:0] res;
        res = ctr;
        if (up) begin
            if (ctr != COUNTER_MAX) res = ctr + 2'd1;
        end else begin
            if (ctr != COUNTER_MIN) res = ctr - 2'd1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/tbp_in_if.sv
// ----------------------------------------------------------------------------
// tbp_in_if
// request channel: predict or update transfer with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface tbp_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] branch_address;
    logic        is_conditional;
    logic        taken;

    modport source (
        output valid, req_type, branch_address, is_conditional, taken,
        input  ready
    );
    modport sink (
        input  valid, req_type, branch_address, is_conditional, taken,
        output ready
    );
endinterface

`default_nettype wire

// File: design/tbp_out_if.sv
// ----------------------------------------------------------------------------
// tbp_out_if
// result channel: direction prediction with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface tbp_out_if;
    logic valid;
    logic ready;
    logic predicted_taken;
    logic used_global;

    modport source (
        output valid, predicted_taken, used_global,
        input  ready
    );
    modport sink (
        input  valid, predicted_taken, used_global,
        output ready
    );
endinterface

`default_nettype wire

// File: design/tournament_branch_predictor_unit.sv
// ----------------------------------------------------------------------------
// tournament_branch_predictor_unit
// gshare + bimodal tournament direction predictor with a 2-bit chooser
// ----------------------------------------------------------------------------
// timing: a non-conditional predict, or an update with no conditional branch
//   on record, puts its result in the output register in the cycle after the
//   transfer; a conditional predict or training update first passes the
//   registered table read and then ST_PRED or ST_UPD before the result register
// a new request waits in ST_IDLE until the last one's table read and
//   write-back are done; reset sweeps both tables to zero, one entry per
//   cycle, with ready held low; history, chooser and saved record cleared
`default_nettype none

module tournament_branch_predictor_unit #(
    parameter int INDEX_BITS   = tbp_pkg::INDEX_BITS_DEF,
    parameter int HISTORY_BITS = tbp_pkg::HISTORY_BITS_DEF
) (
    input  wire i_clk,
    input  wire i_rst_n,
    tbp_in_if.sink    i_req,
    tbp_out_if.source o_rsp
);
    import tbp_pkg::*;

    localparam int TABLE_SIZE = 1 << INDEX_BITS;
    // history is left-aligned in the index when it is not longer than it
    localparam int HIST_SHIFT = (INDEX_BITS >= HISTORY_BITS) ? INDEX_BITS - HISTORY_BITS : 0;

    // counter tables, single write port and single registered read port each
    logic [1:0] r_gmem [TABLE_SIZE];
    logic [1:0] r_amem [TABLE_SIZE];
    logic [1:0] r_g_rd;
    logic [1:0] r_a_rd;

    // sequencer
    t_state r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_idx, n_clr_idx;

    // architectural state
    logic [HISTORY_BITS-1:0] r_hist, n_hist;
    logic [1:0]              r_chooser, n_chooser;
    logic [INDEX_BITS-1:0]   r_sv_gidx, n_sv_gidx;
    logic [INDEX_BITS-1:0]   r_sv_aidx, n_sv_aidx;
    logic                    r_sv_gguess, n_sv_gguess;
    logic                    r_sv_aguess, n_sv_aguess;
    logic                    r_sv_cond, n_sv_cond;

    // outcome of the pending update, held from the request transfer
    logic r_taken_q;
    logic n_taken_q;

    // output register
    logic r_out_valid, n_out_valid;
    logic r_out_pred, n_out_pred;
    logic r_out_glob, n_out_glob;

    // datapath nets
    logic                  req_xfer;
    logic                  is_pred;
    logic [INDEX_BITS-1:0] hist_part;
    logic [INDEX_BITS-1:0] pred_aidx;
    logic [INDEX_BITS-1:0] pred_gidx;
    logic [INDEX_BITS-1:0] rd_gaddr;
    logic [INDEX_BITS-1:0] rd_aaddr;
    logic                  mem_we;
    logic [INDEX_BITS-1:0] wr_gaddr;
    logic [INDEX_BITS-1:0] wr_aaddr;
    logic [1:0]            wr_gdata;
    logic [1:0]            wr_adata;
    logic                  g_ok;
    logic                  a_ok;
    logic                  out_free;

    // a new request is taken only when idle and the result slot frees up
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && out_free;
    assign req_xfer    = i_req.valid && i_req.ready;
    assign is_pred     = (i_req.req_type == REQ_PREDICT);

    // gshare index: low address bits xor the aligned history
    assign hist_part = INDEX_BITS'(r_hist) << HIST_SHIFT;
    assign pred_aidx = i_req.branch_address[INDEX_BITS-1:0];
    assign pred_gidx = hist_part ^ pred_aidx;

    // read at request time: fresh indices on predict, saved ones on update
    assign rd_gaddr = is_pred ? pred_gidx : r_sv_gidx;
    assign rd_aaddr = is_pred ? pred_aidx : r_sv_aidx;

    // component outcomes against the resolved direction
    assign g_ok = (r_sv_gguess == r_taken_q);
    assign a_ok = (r_sv_aguess == r_taken_q);

    // table write: clearing sweep or counter write-back
    always_comb begin
        mem_we   = 1'b0;
        wr_gaddr = r_sv_gidx;
        wr_aaddr = r_sv_aidx;
        wr_gdata = train_ctr(r_g_rd, r_taken_q);
        wr_adata = train_ctr(r_a_rd, r_taken_q);
        case (r_state)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                wr_gaddr = r_clr_idx;
                wr_aaddr = r_clr_idx;
                wr_gdata = COUNTER_MIN;
                wr_adata = COUNTER_MIN;
            end
            ST_UPD: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_gmem[wr_gaddr] <= wr_gdata;
        end
        r_g_rd <= r_gmem[rd_gaddr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_amem[wr_aaddr] <= wr_adata;
        end
        r_a_rd <= r_amem[rd_aaddr];
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + INDEX_BITS'(1);
                if (r_clr_idx == {INDEX_BITS{1'b1}}) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (req_xfer) begin
                    if (is_pred && i_req.is_conditional) begin
                        n_state = ST_PRED;
                    end else if (!is_pred && r_sv_cond) begin
                        n_state = ST_UPD;
                    end
                end
            end
            ST_PRED: n_state = ST_IDLE;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state updates and results
    always_comb begin
        n_hist      = r_hist;
        n_chooser   = r_chooser;
        n_sv_gidx   = r_sv_gidx;
        n_sv_aidx   = r_sv_aidx;
        n_sv_gguess = r_sv_gguess;
        n_sv_aguess = r_sv_aguess;
        n_sv_cond   = r_sv_cond;
        n_taken_q   = r_taken_q;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_pred  = r_out_pred;
        n_out_glob  = r_out_glob;
        case (r_state)
            ST_IDLE: begin
                if (req_xfer) begin
                    n_taken_q = i_req.taken;
                    if (is_pred) begin
                        n_sv_cond = i_req.is_conditional;
                        if (i_req.is_conditional) begin
                            n_sv_gidx = pred_gidx;
                            n_sv_aidx = pred_aidx;
                        end else begin
                            // non-conditional: always taken, result right away
                            n_out_valid = 1'b1;
                            n_out_pred  = 1'b1;
                            n_out_glob  = 1'b0;
                        end
                    end else if (!r_sv_cond) begin
                        // nothing on record to train
                        n_out_valid = 1'b1;
                        n_out_pred  = 1'b0;
                        n_out_glob  = 1'b0;
                    end
                end
            end
            ST_PRED: begin
                n_sv_gguess = r_g_rd[1];
                n_sv_aguess = r_a_rd[1];
                n_out_valid = 1'b1;
                n_out_glob  = r_chooser[1];
                n_out_pred  = r_chooser[1] ? r_g_rd[1] : r_a_rd[1];
            end
            ST_UPD: begin
                n_hist = HISTORY_BITS'({r_hist, r_taken_q});
                if (g_ok && !a_ok) begin
                    n_chooser = train_ctr(r_chooser, 1'b1);
                end else if (a_ok && !g_ok) begin
                    n_chooser = train_ctr(r_chooser, 1'b0);
                end
                n_out_valid = 1'b1;
                n_out_pred  = 1'b0;
                n_out_glob  = 1'b0;
            end
            default: begin
                n_out_valid = r_out_valid && !o_rsp.ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_hist      <= '0;
            r_chooser   <= COUNTER_MIN;
            r_sv_gidx   <= '0;
            r_sv_aidx   <= '0;
            r_sv_gguess <= 1'b0;
            r_sv_aguess <= 1'b0;
            r_sv_cond   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_hist      <= n_hist;
            r_chooser   <= n_chooser;
            r_sv_gidx   <= n_sv_gidx;
            r_sv_aidx   <= n_sv_aidx;
            r_sv_gguess <= n_sv_gguess;
            r_sv_aguess <= n_sv_aguess;
            r_sv_cond   <= n_sv_cond;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_taken_q  <= n_taken_q;
        r_out_pred <= n_out_pred;
        r_out_glob <= n_out_glob;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.predicted_taken = r_out_pred;
    assign o_rsp.used_global     = r_out_glob;

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the tournament branch predictor: directed and
// random predict/update transfers, checked against a behavioral predictor
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import tbp_pkg::*;

    localparam int IDX_W        = INDEX_BITS_DEF;
    localparam int HIST_W       = HISTORY_BITS_DEF;
    localparam int TABLE_DEPTH  = 1 << IDX_W;
    // the reset sweep alone holds ready low while it clears every table entry
    localparam int STALL_LIMIT  = 4 * TABLE_DEPTH + 10000;
    localparam int RANDOM_ITEMS = 1725;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOT_SLOTS    = 16;
    localparam int REPORT_MAX   = 10;

    // one request transfer
    typedef struct packed {
        logic        req_type;
        logic [31:0] branch_address;
        logic        is_conditional;
        logic        taken;
    } t_branch_req;

    // one result transfer
    typedef struct packed {
        logic predicted_taken;
        logic used_global;
    } t_direction;

    // ------------------------------------------------------------------------
    // direction predictor mirror and queue of predicted results
    // ------------------------------------------------------------------------
    class direction_scoreboard;
        logic [1:0]        gshare_ctr  [TABLE_DEPTH];
        logic [1:0]        bimodal_ctr [TABLE_DEPTH];
        logic [HIST_W-1:0] history;
        logic [1:0]        chooser;
        logic [IDX_W-1:0]  last_gshare_idx;
        logic [IDX_W-1:0]  last_bimodal_idx;
        logic              last_gshare_guess;
        logic              last_bimodal_guess;
        logic              last_conditional;
        t_direction        pending_q[$];
        int                mismatches;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                gshare_ctr[i]  = 2'd0;
                bimodal_ctr[i] = 2'd0;
            end
            history            = '0;
            chooser            = 2'd0;
            last_gshare_idx    = '0;
            last_bimodal_idx   = '0;
            last_gshare_guess  = 1'b0;
            last_bimodal_guess = 1'b0;
            last_conditional   = 1'b0;
            mismatches         = 0;
        endfunction

        function logic [1:0] saturate(logic [1:0] ctr, logic up);
            if (up) begin
                return (ctr == 2'd3) ? ctr : ctr + 2'd1;
            end
            return (ctr == 2'd0) ? ctr : ctr - 2'd1;
        endfunction

        // history aligned to the top of the index, or truncated when longer
        function logic [IDX_W-1:0] history_index();
            logic [63:0] h;
            int          shift;
            h     = 64'(history);
            shift = IDX_W - HIST_W;
            if (shift >= 0) begin
                h = h << shift;
            end
            return h[IDX_W-1:0];
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("%s", msg);
            end
        endfunction

        function void note_request(t_branch_req r);
            t_direction       want;
            logic [IDX_W-1:0] ai;
            logic             g_ok;
            logic             a_ok;
            want = '0;
            if (r.req_type == REQ_PREDICT) begin
                last_conditional = r.is_conditional;
                if (r.is_conditional) begin
                    ai                 = r.branch_address[IDX_W-1:0];
                    last_bimodal_idx   = ai;
                    last_gshare_idx    = history_index() ^ ai;
                    last_gshare_guess  = gshare_ctr[last_gshare_idx][1];
                    last_bimodal_guess = bimodal_ctr[ai][1];
                    if (chooser[1]) begin
                        want.predicted_taken = last_gshare_guess;
                        want.used_global     = 1'b1;
                    end else begin
                        want.predicted_taken = last_bimodal_guess;
                    end
                end else begin
                    want.predicted_taken = 1'b1;
                end
            end else if (last_conditional) begin
                g_ok = (last_gshare_guess == r.taken);
                a_ok = (last_bimodal_guess == r.taken);
                gshare_ctr[last_gshare_idx] =
                    saturate(gshare_ctr[last_gshare_idx], r.taken);
                bimodal_ctr[last_bimodal_idx] =
                    saturate(bimodal_ctr[last_bimodal_idx], r.taken);
                history = (history << 1) | HIST_W'(r.taken);
                if (g_ok && !a_ok) begin
                    chooser = saturate(chooser, 1'b1);
                end else if (a_ok && !g_ok) begin
                    chooser = saturate(chooser, 1'b0);
                end
            end
            pending_q.push_back(want);
        endfunction

        function void check_response(t_direction got);
            t_direction want;
            if (pending_q.size() == 0) begin
                flag($sformatf("result with nothing pending: taken=%0b global=%0b",
                               got.predicted_taken, got.used_global));
                return;
            end
            want = pending_q.pop_front();
            if (got.predicted_taken !== want.predicted_taken) begin
                flag($sformatf("predicted_taken: expected %0b, got %0b",
                               want.predicted_taken, got.predicted_taken));
            end
            if (got.used_global !== want.used_global) begin
                flag($sformatf("used_global: expected %0b, got %0b",
                               want.used_global, got.used_global));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tbp_in_if  req_bus ();
    tbp_out_if rsp_bus ();

    tournament_branch_predictor_unit #(
        .INDEX_BITS   (IDX_W),
        .HISTORY_BITS (HIST_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    direction_scoreboard board;

    // transfers left in a no-gap stretch, one per side
    int send_calm;
    int recv_calm;

    // counts transfers that change predictor state or carry a prediction
    int  useful_count;
    bit  armed;

    int  idle_cycles;

    // a few hot table indices so counters saturate and the chooser moves
    logic [IDX_W-1:0] hot_index [HOT_SLOTS];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // gap before a transfer: 0..3, with occasional runs of back-to-back
    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 63) == 0) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    // ignored fields get random values too
    function automatic t_branch_req make_predict(logic [31:0] addr, logic cond);
        t_branch_req r;
        r.req_type       = REQ_PREDICT;
        r.branch_address = addr;
        r.is_conditional = cond;
        r.taken          = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_branch_req make_update(logic tk);
        t_branch_req r;
        r.req_type       = REQ_UPDATE;
        r.branch_address = $urandom;
        r.is_conditional = 1'($urandom_range(0, 1));
        r.taken          = tk;
        return r;
    endfunction

    // mostly hot indices with random upper bits, sometimes any address
    function automatic logic [31:0] pick_address();
        logic [31:0] addr;
        addr = $urandom;
        if ($urandom_range(0, 9) != 0) begin
            addr[IDX_W-1:0] = hot_index[$urandom_range(0, HOT_SLOTS - 1)];
        end
        return addr;
    endfunction

    // each index leans one way so the counters learn something
    function automatic logic pick_outcome(logic [31:0] addr);
        if ($urandom_range(0, 4) != 0) begin
            return ^addr[IDX_W-1:0];
        end
        return 1'($urandom_range(0, 1));
    endfunction

    // one request transfer on the input channel
    task automatic send_request(input t_branch_req r);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.req_type       <= r.req_type;
        req_bus.branch_address <= r.branch_address;
        req_bus.is_conditional <= r.is_conditional;
        req_bus.taken          <= r.taken;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        board.note_request(r);
    endtask

    task automatic issue(input t_branch_req r);
        send_request(r);
        if (r.req_type == REQ_PREDICT) begin
            useful_count++;
            armed = r.is_conditional;
        end else if (armed) begin
            useful_count++;
        end
    endtask

    // stimulus
    initial begin
        int          pick;
        int          repeats;
        logic [31:0] addr;
        board        = new();
        send_calm    = 0;
        useful_count = 0;
        armed        = 1'b0;
        for (int i = 0; i < HOT_SLOTS; i++) begin
            hot_index[i] = IDX_W'($urandom);
        end
        hot_index[0] = '0;
        hot_index[1] = '1;

        i_rst_n                <= 1'b0;
        req_bus.valid          <= 1'b0;
        req_bus.req_type       <= REQ_PREDICT;
        req_bus.branch_address <= '0;
        req_bus.is_conditional <= 1'b0;
        req_bus.taken          <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // update with no branch on record since reset
        issue(make_update(1'b1));
        // unconditional branch, then an update that must be ignored
        issue(make_predict(32'h0000_0000, 1'b0));
        issue(make_update(1'b1));
        // conditional branch trained twice by back-to-back updates
        issue(make_predict(32'h0000_0000, 1'b1));
        issue(make_update(1'b1));
        issue(make_update(1'b1));
        // top of the address range
        issue(make_predict(32'hffff_ffff, 1'b1));
        issue(make_update(1'b0));
        // two predicts in a row, only the second one is on record
        issue(make_predict(32'h5555_aaaa, 1'b1));
        issue(make_predict(32'haaaa_5555, 1'b1));
        // saturate one bimodal entry, then turn it around so gshare wins
        repeat (4) begin
            issue(make_predict(32'h0000_8000, 1'b1));
            issue(make_update(1'b1));
        end
        repeat (4) begin
            issue(make_predict(32'h0000_8000, 1'b1));
            issue(make_update(1'b0));
        end

        // random part: mostly predict/update pairs, the rest noise
        useful_count = 0;
        while (useful_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            addr = pick_address();
            if (pick < 70) begin
                issue(make_predict(addr, 1'b1));
                issue(make_update(pick_outcome(addr)));
            end else if (pick < 78) begin
                repeats = $urandom_range(2, 3);
                issue(make_predict(addr, 1'b1));
                repeat (repeats) issue(make_update(pick_outcome(addr)));
            end else if (pick < 86) begin
                issue(make_predict(addr, 1'b0));
                issue(make_update(1'($urandom_range(0, 1))));
            end else if (pick < 92) begin
                issue(make_update(1'($urandom_range(0, 1))));
            end else begin
                issue(make_predict(addr, 1'($urandom_range(0, 1))));
            end
        end
        req_bus.valid <= 1'b0;

        // drain, then give the block a few more cycles to misbehave
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // result side: random backpressure, every transfer checked
    initial begin
        int         gap;
        t_direction got;
        recv_calm     = 0;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            gap = draw_wait(recv_calm);
            if (gap > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_bus.valid !== 1'b1);
            got.predicted_taken = rsp_bus.predicted_taken;
            got.used_global     = rsp_bus.used_global;
            board.check_response(got);
        end
    end

    // watchdog: long stretch with no transfer on either channel
    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire

// File: sim.f
design/tbp_pkg.sv
design/tbp_in_if.sv
design/tbp_out_if.sv
design/tournament_branch_predictor_unit.sv
bench/testbench.sv
